// ===== sv/ott_pkg.sv =====
// Shared types and constants for the one-shot timer table.
// No dependencies; imported by ott_scan and one_shot_timer_table_unit.
package ott_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int REM_W           = 48;
	localparam int ID_W            = 32;
	localparam int DELTA_W         = 32;
	localparam int PCNT_W          = 5;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		EV_ACCEPTED = 2'd0,
		EV_FULL     = 2'd1,
		EV_EXPIRED  = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [REM_W-1:0] rem;
	} slot_t;

endpackage

// ===== sv/ott_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ott_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ott_scan.sv =====
// Tick walk engine: reads the slot RAM one entry per cycle, compacts survivors
// in place and writes expired IDs to the expiry RAM. Depends on ott_pkg.
module ott_scan #(
	parameter int TIMER_SLOTS = ott_pkg::TIMER_SLOTS_DEF,
	localparam int CNT_W      = $clog2(TIMER_SLOTS + 1),
	localparam int IDX_W      = $clog2(TIMER_SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ott_pkg::DELTA_W-1:0] delta,
	input  logic [CNT_W-1:0]           count,
	output logic                       busy,
	output logic                       slot_re,
	output logic [IDX_W-1:0]           slot_raddr,
	input  ott_pkg::slot_t             slot_rdata,
	output logic                       slot_we,
	output logic [IDX_W-1:0]           slot_waddr,
	output ott_pkg::slot_t             slot_wdata,
	output logic                       exp_we,
	output logic [IDX_W-1:0]           exp_waddr,
	output logic [ott_pkg::ID_W-1:0]   exp_wdata,
	output logic                       done,
	output logic [CNT_W-1:0]           keep_cnt,
	output logic [CNT_W-1:0]           exp_cnt
);

	import ott_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   keep_q;
	logic [CNT_W-1:0]   nexp_q;
	logic [DELTA_W-1:0] delta_q;
	logic               vld_s1;
	logic [CNT_W-1:0]   idx_s1;

	logic             rd_go;
	logic             hit;
	logic             last_s1;
	logic [REM_W-1:0] delta_ext;

	assign delta_ext = {{(REM_W - DELTA_W){1'b0}}, delta_q};
	assign rd_go     = busy_q && (rd_idx_q != cnt_q);
	assign hit       = delta_ext >= slot_rdata.rem;
	assign last_s1   = vld_s1 && (idx_s1 == (cnt_q - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			keep_q   <= '0;
			nexp_q   <= '0;
			delta_q  <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= count;
				delta_q  <= delta;
				rd_idx_q <= '0;
				keep_q   <= '0;
				nexp_q   <= '0;
				vld_s1   <= 1'b0;
			end else if (busy_q) begin
				vld_s1 <= rd_go;
				idx_s1 <= rd_idx_q;
				if (rd_go) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (vld_s1) begin
					if (hit) begin
						nexp_q <= nexp_q + CNT_W'(1);
					end else begin
						keep_q <= keep_q + CNT_W'(1);
					end
				end
				if (last_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// writes land at or below the entry in stage 1, always behind the read pointer
	assign slot_re         = rd_go;
	assign slot_raddr      = rd_idx_q[IDX_W-1:0];
	assign slot_we         = vld_s1 && !hit;
	assign slot_waddr      = keep_q[IDX_W-1:0];
	assign slot_wdata.id   = slot_rdata.id;
	assign slot_wdata.rem  = slot_rdata.rem - delta_ext;
	assign exp_we          = vld_s1 && hit;
	assign exp_waddr       = nexp_q[IDX_W-1:0];
	assign exp_wdata       = slot_rdata.id;
	assign busy            = busy_q;
	assign done            = done_q;
	assign keep_cnt        = keep_q;
	assign exp_cnt         = nexp_q;

endmodule

// ===== sv/one_shot_timer_table_unit.sv =====
// Top level of the one-shot timer table: control FSM, ID counter, output register.
// Depends on ott_pkg, ott_ram and ott_scan.
//
// Input stream: tuser = opcode (set, tick, clear), tdata = duration and tick delta.
// Output stream: tuser = event kind, tdata = timer ID and pending count, tlast
// marks the final result of one input transfer.
// Set: one result, loaded into the output register the cycle after the transfer.
// Full table answers with kind "full" and ID 0.
// Tick: walks the N pending slots at one per cycle through the slot RAM read
// port, then reports each expired timer in table order, each result by an
// expiry RAM read, then a load. A tick with no expiry gives no result.
// Clear and the unused opcode give no result.
// Input is taken only while idle and the output register is free or draining.
// A stalled receiver holds the output register and pauses expiry reporting.
// Reset empties the table and zeroes the ID counter; no clearing pass is needed.
module one_shot_timer_table_unit #(
	parameter int TIMER_SLOTS = ott_pkg::TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // duration_ns[47:0], tick_delta_ns[79:48]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // timer_id[31:0], pending_count[36:32], zero[39:37]
	output logic [1:0]  m_axis_tuser,   // event_kind[1:0]
	output logic        m_axis_tlast
);

	import ott_pkg::*;

	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int IDX_W = $clog2(TIMER_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RD,
		ST_LOAD
	} state_t;

	state_t            st_q;
	logic [CNT_W-1:0]  pending_q;
	logic [ID_W-1:0]   next_id_q;
	logic [CNT_W-1:0]  dr_idx_q;
	logic [CNT_W-1:0]  nexp_tot_q;
	logic              out_valid_q;
	event_kind_t       out_kind_q;
	logic [ID_W-1:0]   out_id_q;
	logic [PCNT_W-1:0] out_cnt_q;
	logic              out_last_q;

	opcode_t          op;
	logic             in_fire;
	logic             out_free;
	logic             full;
	logic             set_we;
	logic             scan_start;
	logic [ID_W-1:0]  set_id;
	logic [CNT_W+PCNT_W-1:0] inc_ext;
	logic [CNT_W+PCNT_W-1:0] cur_ext;
	logic             dr_last;

	logic             slot_we;
	logic [IDX_W-1:0] slot_waddr;
	slot_t            slot_wdata;
	slot_t            slot_rdata;
	logic             scan_busy;
	logic             scan_re;
	logic [IDX_W-1:0] scan_raddr;
	logic             scan_we;
	logic [IDX_W-1:0] scan_waddr;
	slot_t            scan_wdata;
	logic             exp_we;
	logic [IDX_W-1:0] exp_waddr;
	logic [ID_W-1:0]  exp_wdata;
	logic [ID_W-1:0]  exp_rdata;
	logic             scan_done;
	logic [CNT_W-1:0] scan_keep;
	logic [CNT_W-1:0] scan_nexp;

	assign op            = opcode_t'(s_axis_tuser);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE) && out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign full          = pending_q == CNT_W'(TIMER_SLOTS);
	assign set_id        = (pending_q == '0) ? '0 : next_id_q;
	assign set_we        = in_fire && (op == OP_SET) && !full;
	assign scan_start    = in_fire && (op == OP_TICK) && (pending_q != '0);
	assign inc_ext       = {{PCNT_W{1'b0}}, pending_q + CNT_W'(1)};
	assign cur_ext       = {{PCNT_W{1'b0}}, pending_q};
	assign dr_last       = dr_idx_q == (nexp_tot_q - CNT_W'(1));

	assign slot_we    = set_we || scan_we;
	assign slot_waddr = set_we ? pending_q[IDX_W-1:0] : scan_waddr;
	always_comb begin
		if (set_we) begin
			slot_wdata.id  = set_id;
			slot_wdata.rem = s_axis_tdata[REM_W-1:0];
		end else begin
			slot_wdata = scan_wdata;
		end
	end

	ott_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(TIMER_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (scan_re),
		.raddr(scan_raddr),
		.rdata(slot_rdata)
	);

	ott_ram #(
		.WIDTH(ID_W),
		.DEPTH(TIMER_SLOTS)
	) u_exp_ram (
		.clk  (clk),
		.we   (exp_we),
		.waddr(exp_waddr),
		.wdata(exp_wdata),
		.re   (st_q == ST_RD),
		.raddr(dr_idx_q[IDX_W-1:0]),
		.rdata(exp_rdata)
	);

	ott_scan #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.delta     (s_axis_tdata[REM_W+DELTA_W-1:REM_W]),
		.count     (pending_q),
		.busy      (scan_busy),
		.slot_re   (scan_re),
		.slot_raddr(scan_raddr),
		.slot_rdata(slot_rdata),
		.slot_we   (scan_we),
		.slot_waddr(scan_waddr),
		.slot_wdata(scan_wdata),
		.exp_we    (exp_we),
		.exp_waddr (exp_waddr),
		.exp_wdata (exp_wdata),
		.done      (scan_done),
		.keep_cnt  (scan_keep),
		.exp_cnt   (scan_nexp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pending_q   <= '0;
			next_id_q   <= '0;
			dr_idx_q    <= '0;
			nexp_tot_q  <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= EV_ACCEPTED;
			out_id_q    <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (op)
							OP_SET: begin
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b1;
								if (full) begin
									out_kind_q <= EV_FULL;
									out_id_q   <= '0;
									out_cnt_q  <= cur_ext[PCNT_W-1:0];
								end else begin
									out_kind_q <= EV_ACCEPTED;
									out_id_q   <= set_id;
									out_cnt_q  <= inc_ext[PCNT_W-1:0];
									pending_q  <= pending_q + CNT_W'(1);
									next_id_q  <= set_id + ID_W'(1);
								end
							end
							OP_TICK: begin
								if (pending_q != '0) begin
									st_q <= ST_WALK;
								end
							end
							OP_CLEAR: begin
								pending_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (scan_done) begin
						pending_q <= scan_keep;
						if (scan_nexp == '0) begin
							st_q <= ST_IDLE;
						end else begin
							nexp_tot_q <= scan_nexp;
							dr_idx_q   <= '0;
							st_q       <= ST_RD;
						end
					end
				end
				ST_RD: begin
					st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= EV_EXPIRED;
						out_id_q    <= exp_rdata;
						out_cnt_q   <= cur_ext[PCNT_W-1:0];
						out_last_q  <= dr_last;
						dr_idx_q    <= dr_idx_q + CNT_W'(1);
						st_q        <= dr_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {3'b000, out_cnt_q, out_id_q};
	assign m_axis_tlast  = out_last_q;

	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !scan_busy)
		else $error("input accepted while walk engine busy");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(TIMER_SLOTS))
		else $error("pending count above table size");

	a_walk_conserves: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (({1'b0, scan_keep} + {1'b0, scan_nexp}) == {1'b0, pending_q}))
		else $error("walk lost or duplicated entries");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD) |-> (dr_idx_q < nexp_tot_q))
		else $error("expiry drain index out of range");

endmodule
